// ----- src/opi_pkg.sv -----
// Shared constants and the arctangent table for the odometry pose integrator.
`timescale 1ns / 1ps

package opi_pkg;

  localparam int POS_W   = 32;            // Q16.16 position
  localparam int ANG_W   = 16;            // binary angle, full turn = 2^16
  localparam int DLT_W   = POS_W + 1;     // exact position difference
  localparam int XY_W    = 36;            // rotation datapath, covers CORDIC growth
  localparam int Z_W     = 34;            // residual angle, full turn = 2^32
  localparam int GAIN_W  = 16;            // gain factor in Q0.16
  localparam int ACC_W   = XY_W + GAIN_W; // gain product
  localparam int SUM_W   = XY_W + 1;      // estimate plus rotated delta
  localparam int ATAN_LEN = 24;
  localparam int IDX_W   = $clog2(ATAN_LEN);

  localparam logic [GAIN_W-1:0] GAIN_Q16 = 16'd39797;
  localparam logic [ACC_W-1:0]  ROUND_HALF = ACC_W'(32768);
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 16'sd16384;

  // atan(2^-i) in 2^32-per-turn units
  function automatic logic signed [Z_W-1:0] atan_entry(input logic [IDX_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    v = '0;
    case (idx)
      5'd0:  v = 34'sd536870912;
      5'd1:  v = 34'sd316933406;
      5'd2:  v = 34'sd167458907;
      5'd3:  v = 34'sd85004756;
      5'd4:  v = 34'sd42667331;
      5'd5:  v = 34'sd21354465;
      5'd6:  v = 34'sd10679838;
      5'd7:  v = 34'sd5340245;
      5'd8:  v = 34'sd2670163;
      5'd9:  v = 34'sd1335087;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41722;
      5'd15: v = 34'sd20861;
      5'd16: v = 34'sd10430;
      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2608;
      5'd19: v = 34'sd1304;
      5'd20: v = 34'sd652;
      5'd21: v = 34'sd326;
      5'd22: v = 34'sd163;
      5'd23: v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- src/odometry_pose_integrator.sv -----
// Planar dead-reckoning pose integrator with iterative rotation and bit-serial gain.
`timescale 1ns / 1ps

// Each input beat is an odometry report (tuser = 0) or a rearm command (tuser = 1);
// each beat yields exactly one output beat with the current pose estimate. The
// first report after reset or rearm copies the reported pose into the estimate;
// later reports rotate the reported position change by (estimated heading minus
// previous reported yaw) and add it with saturation, while the yaw change is added
// to the heading modulo a full turn. Items are handled one at a time. A rearm or a
// first report goes from accept straight to the FINISH state, where it commits into
// the output register. Any other report passes through ROTATION_STEPS steps in the
// shared CORDIC add/subtract unit, the gain multiplier, which consumes the constant
// 0.60725 one bit per cycle, a rounding step and a saturating add. The input is
// ready again the cycle after the output register loads, so a new report is taken
// only once the last one is through. The output register holds a finished beat
// while the next item is accepted and worked on; a finished item waits only if
// that beat is still not taken. ROTATION_STEPS above 24 behaves as 24.
module odometry_pose_integrator
  import opi_pkg::*;
#(
  parameter int ROTATION_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // odom_x[31:0], odom_y[63:32], odom_yaw[79:64]
  input  logic        s_tuser,   // mode: 0 report, 1 rearm
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // pose_x_out[31:0], pose_y_out[63:32], heading[79:64]
  output logic        m_tuser    // initialised
);

  localparam int STEPS = (ROTATION_STEPS > ATAN_LEN) ? ATAN_LEN : ROTATION_STEPS;
  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(STEPS - 1);
  localparam int GCNT_W = $clog2(GAIN_W);

  typedef enum logic [2:0] {IDLE, ROTATE, GAIN, ROUND, FINISH} state_t;
  typedef enum logic [1:0] {KIND_REARM, KIND_FIRST, KIND_UPDATE} kind_t;

  state_t state;
  kind_t  kind;

  // Estimator state
  logic                     awaiting_first;
  logic signed [POS_W-1:0]  prev_x, prev_y, est_x, est_y;
  logic signed [ANG_W-1:0]  prev_yaw, est_heading;

  // Captured report
  logic signed [POS_W-1:0]  in_x, in_y;
  logic signed [ANG_W-1:0]  in_yaw;

  // Rotation and gain datapath
  logic signed [XY_W-1:0]   x, y;
  logic signed [Z_W-1:0]    z;
  logic [IDX_W-1:0]         step;
  logic signed [ACC_W-1:0]  acc_x, acc_y;
  logic [GAIN_W-1:0]        gsr;
  logic [GCNT_W-1:0]        gcnt;

  // Input side decode
  logic signed [POS_W-1:0]  ox, oy;
  logic signed [ANG_W-1:0]  oyaw, ang, ang_fold;
  logic signed [DLT_W-1:0]  dx, dy;
  logic                     fold;

  assign ox   = s_tdata[31:0];
  assign oy   = s_tdata[63:32];
  assign oyaw = s_tdata[79:64];
  assign dx   = {ox[POS_W-1], ox} - {prev_x[POS_W-1], prev_x};
  assign dy   = {oy[POS_W-1], oy} - {prev_y[POS_W-1], prev_y};
  assign ang  = est_heading - prev_yaw;
  // Fold the angle into [-quarter, +quarter] turn by a half-turn flip
  assign fold = (ang > QUARTER_TURN) || (ang < -QUARTER_TURN);
  assign ang_fold = fold ? (ang ^ 16'sh8000) : ang;

  // One CORDIC micro-rotation
  logic signed [XY_W-1:0]   xs, ys;
  logic signed [Z_W-1:0]    atan_v;
  assign xs     = x >>> step;
  assign ys     = y >>> step;
  assign atan_v = atan_entry(step);

  // Gain digit: the current multiplier bit selects the operand
  logic signed [ACC_W-1:0]  x_ext, y_ext, acc_x_next, acc_y_next;
  assign x_ext = ACC_W'(x);
  assign y_ext = ACC_W'(y);
  assign acc_x_next = (acc_x <<< 1) + (gsr[GAIN_W-1] ? x_ext : '0);
  assign acc_y_next = (acc_y <<< 1) + (gsr[GAIN_W-1] ? y_ext : '0);

  // Round half up and drop the 16 fraction bits
  logic signed [ACC_W-1:0]  rnd_x, rnd_y;
  assign rnd_x = (acc_x + $signed(ROUND_HALF)) >>> GAIN_W;
  assign rnd_y = (acc_y + $signed(ROUND_HALF)) >>> GAIN_W;

  // Saturating update of the estimate
  function automatic logic signed [POS_W-1:0] sat_add(input logic signed [POS_W-1:0] a,
                                                      input logic signed [XY_W-1:0]  b);
    logic signed [SUM_W-1:0] s;
    logic signed [SUM_W-1:0] hi, lo;
    hi = SUM_W'(32'sh7fffffff);
    lo = -hi - SUM_W'(1);
    s  = SUM_W'(a) + SUM_W'(b);
    if (s > hi) begin
      return 32'sh7fffffff;
    end else if (s < lo) begin
      return 32'sh80000000;
    end
    return s[POS_W-1:0];
  endfunction

  logic signed [POS_W-1:0]  upd_x, upd_y;
  logic signed [ANG_W-1:0]  upd_heading;
  logic                     out_free;

  assign upd_x       = sat_add(est_x, x);
  assign upd_y       = sat_add(est_y, y);
  assign upd_heading = est_heading + in_yaw - prev_yaw;
  assign out_free    = !m_tvalid || m_tready;
  assign s_tready    = (state == IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      kind           <= KIND_REARM;
      m_tvalid       <= 1'b0;
      awaiting_first <= 1'b1;
      prev_x         <= '0;
      prev_y         <= '0;
      prev_yaw       <= '0;
      est_x          <= '0;
      est_y          <= '0;
      est_heading    <= '0;
      step           <= '0;
      gcnt           <= '0;
    end else begin
      // Drop the output beat once taken, unless a commit reloads it this cycle
      if (m_tvalid && m_tready && (state != FINISH)) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        IDLE: begin
          if (s_tvalid) begin
            in_x   <= ox;
            in_y   <= oy;
            in_yaw <= oyaw;
            if (s_tuser) begin
              kind  <= KIND_REARM;
              state <= FINISH;
            end else if (awaiting_first) begin
              kind  <= KIND_FIRST;
              state <= FINISH;
            end else begin
              kind  <= KIND_UPDATE;
              x     <= fold ? -XY_W'(dx) : XY_W'(dx);
              y     <= fold ? -XY_W'(dy) : XY_W'(dy);
              z     <= {{(Z_W-ANG_W-16){ang_fold[ANG_W-1]}}, ang_fold, 16'b0};
              step  <= '0;
              state <= ROTATE;
            end
          end
        end

        ROTATE: begin
          if (!z[Z_W-1]) begin
            x <= x - ys;
            y <= y + xs;
            z <= z - atan_v;
          end else begin
            x <= x + ys;
            y <= y - xs;
            z <= z + atan_v;
          end
          step <= step + IDX_W'(1);
          if (step == LAST_STEP) begin
            acc_x <= '0;
            acc_y <= '0;
            gsr   <= GAIN_Q16;
            gcnt  <= '0;
            state <= GAIN;
          end
        end

        GAIN: begin
          acc_x <= acc_x_next;
          acc_y <= acc_y_next;
          gsr   <= gsr << 1;
          gcnt  <= gcnt + GCNT_W'(1);
          if (gcnt == GCNT_W'(GAIN_W - 1)) begin
            state <= ROUND;
          end
        end

        ROUND: begin
          x     <= rnd_x[XY_W-1:0];
          y     <= rnd_y[XY_W-1:0];
          state <= FINISH;
        end

        FINISH: begin
          // Hold until the output register is free, then commit and emit
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= IDLE;
            case (kind)
              KIND_REARM: begin
                awaiting_first <= 1'b1;
                m_tdata        <= {est_heading, est_y, est_x};
                m_tuser        <= 1'b0;
              end
              KIND_FIRST: begin
                awaiting_first <= 1'b0;
                prev_x         <= in_x;
                prev_y         <= in_y;
                prev_yaw       <= in_yaw;
                est_x          <= in_x;
                est_y          <= in_y;
                est_heading    <= in_yaw;
                m_tdata        <= {in_yaw, in_y, in_x};
                m_tuser        <= 1'b1;
              end
              default: begin
                prev_x         <= in_x;
                prev_y         <= in_y;
                prev_yaw       <= in_yaw;
                est_x          <= upd_x;
                est_y          <= upd_y;
                est_heading    <= upd_heading;
                m_tdata        <= {upd_heading, upd_y, upd_x};
                m_tuser        <= 1'b1;
              end
            endcase
          end
        end

        default: state <= IDLE;
      endcase
    end
  end

  // A commit always presents a beat whose flag matches the new arming state
  assert property (@(posedge clk) disable iff (rst)
    (state == FINISH && out_free) |=> (m_tvalid && (m_tuser == !awaiting_first)))
    else $error("output flag does not follow arming state");

  // Rearm and first reports skip the arithmetic
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser || awaiting_first)) |=> (state == FINISH))
    else $error("short item did not go straight to commit");

  // The folded start angle lies within a quarter turn
  assert property (@(posedge clk) disable iff (rst)
    (state == ROTATE && step == '0) |->
      (z <= 34'sd1073741824 && z >= -34'sd1073741824))
    else $error("rotation angle not folded");

  // The step counter never runs past the table
  assert property (@(posedge clk) disable iff (rst)
    (state == ROTATE) |-> (step <= LAST_STEP))
    else $error("rotation step out of range");

  // A report that needs rotation passes through the gain stage before commit
  assert property (@(posedge clk) disable iff (rst)
    (state == ROUND) |-> ($past(state) == GAIN))
    else $error("rounding entered without gain pass");

endmodule
